// File: sv/shfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfp_pkg
// Shared types and constants of the sync header frame parser.
// ----------------------------------------------------------------------------
package shfp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ByteW-1:0] SyncFirstRst  = 8'hAA;
  localparam logic [ByteW-1:0] SyncSecondRst = 8'hBB;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgSyncFirst  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSyncSecond = 1'b1;

  // Result status codes.
  localparam logic [StatusW-1:0] StNew = 2'd0;
  localparam logic [StatusW-1:0] StDup = 2'd1;
  localparam logic [StatusW-1:0] StErr = 2'd2;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   serial;
    logic [ByteW-1:0]   kind;
    logic [ByteW-1:0]   payload_low;
    logic [ByteW-1:0]   payload_high;
  } result_t;

endpackage

// File: sv/shfp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfp_parser
// Frame FSM, running check, duplicate tracking; one byte per accepted cycle.
// ----------------------------------------------------------------------------
module shfp_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [shfp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [shfp_pkg::ByteW-1:0]    cfg_data,
  input  logic                          accept,
  input  logic [shfp_pkg::ByteW-1:0]    rx_byte,
  output logic                          emit,
  output shfp_pkg::result_t             result
);
  import shfp_pkg::*;

  typedef enum logic [2:0] {
    PhSync1  = 3'd0,
    PhSync2  = 3'd1,
    PhSerial = 3'd2,
    PhKind   = 3'd3,
    PhDataLo = 3'd4,
    PhDataHi = 3'd5,
    PhCheck  = 3'd6
  } phase_t;

  phase_t           phase, phase_next;
  logic [ByteW-1:0] sync_first, sync_second;
  logic [ByteW-1:0] running_xor, running_xor_next;
  logic [ByteW-1:0] held_serial, held_kind, held_low, held_high;
  logic [ByteW-1:0] last_serial;
  logic             last_valid;
  logic             is_first;

  assign is_first = (rx_byte == sync_first);

  always_comb begin
    phase_next       = phase;
    running_xor_next = running_xor ^ rx_byte;
    emit             = 1'b0;
    result.status    = StNew;
    result.serial    = held_serial;
    result.kind      = held_kind;
    result.payload_low  = held_low;
    result.payload_high = held_high;
    unique case (phase)
      PhSync2: begin
        if (rx_byte == sync_second) begin
          phase_next = PhSerial;
        end else begin
          phase_next       = is_first ? PhSync2 : PhSync1;
          running_xor_next = rx_byte;
        end
      end
      PhSerial: phase_next = PhKind;
      PhKind:   phase_next = PhDataLo;
      PhDataLo: phase_next = PhDataHi;
      PhDataHi: phase_next = PhCheck;
      PhCheck: begin
        emit = 1'b1;
        if (running_xor == rx_byte) begin
          phase_next    = PhSync1;
          result.status = (last_valid && held_serial == last_serial) ? StDup : StNew;
        end else begin
          phase_next       = is_first ? PhSync2 : PhSync1;
          running_xor_next = rx_byte;
          result.status    = StErr;
        end
      end
      default: begin
        // Hunting for the first sync byte; the unused code behaves the same.
        phase_next       = is_first ? PhSync2 : PhSync1;
        running_xor_next = rx_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PhSync1;
      running_xor <= '0;
      held_serial <= '0;
      held_kind   <= '0;
      held_low    <= '0;
      held_high   <= '0;
      last_serial <= '0;
      last_valid  <= 1'b0;
      sync_first  <= SyncFirstRst;
      sync_second <= SyncSecondRst;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CfgSyncFirst:  sync_first  <= cfg_data;
          CfgSyncSecond: sync_second <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        phase       <= phase_next;
        running_xor <= (phase_next == PhSync1) ? running_xor : running_xor_next;
        if (phase == PhSerial) held_serial <= rx_byte;
        if (phase == PhKind)   held_kind   <= rx_byte;
        if (phase == PhDataLo) held_low    <= rx_byte;
        if (phase == PhDataHi) held_high   <= rx_byte;
        if (emit && result.status == StNew) begin
          last_serial <= held_serial;
          last_valid  <= 1'b1;
        end
      end
    end
  end

  // The running check does not matter while hunting; only its value after a
  // first sync byte is used, and that is loaded directly from the byte.

  a_emit_only_on_check: assert property (@(posedge clk) disable iff (rst)
    emit |-> phase == PhCheck)
    else $error("result raised outside the check phase");

  a_check_leaves_frame: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PhCheck) |=> (phase == PhSync1 || phase == PhSync2))
    else $error("parser stayed inside a frame after its check byte");

  a_last_valid_sticky: assert property (@(posedge clk) disable iff (rst)
    last_valid |=> last_valid)
    else $error("last serial marker dropped without reset");

  a_new_records_serial: assert property (@(posedge clk) disable iff (rst)
    (accept && emit && result.status == StNew) |=>
      (last_valid && last_serial == $past(held_serial)))
    else $error("new frame did not record its serial");

endmodule

// File: sv/shfp_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfp_out_stage
// Result register with valid/ready handshake towards the receiver.
// ----------------------------------------------------------------------------
module shfp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  shfp_pkg::result_t load_data,
  output logic              can_take,
  output logic              out_valid,
  input  logic              out_ready,
  output shfp_pkg::result_t out_data
);
  import shfp_pkg::*;

  // A new word may be loaded whenever the held one leaves in this cycle.
  assign can_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> can_take)
    else $error("held result overwritten while stalled");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == StNew || out_data.status == StDup ||
                   out_data.status == StErr))
    else $error("illegal status code in result register");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

// File: sv/sync_header_frame_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_header_frame_parser_top
// Byte-stream parser for seven-byte frames with two sync bytes and XOR check.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, rx_byte) carries one received byte
// per word. Frames are two sync bytes, serial, type, two data bytes and a
// check byte equal to the XOR of the six bytes before it. Each check byte
// produces one word on the output channel (out_valid, out_ready and the
// frame fields): status new, duplicate serial, or check mismatch. All other
// bytes produce nothing.
// A result is presented on the cycle after its check byte is accepted.
// Throughput is one byte per cycle while in_ready stays high; the parser
// state machine advances on every accepted byte.
// The sync byte values are set through cfg_we, cfg_index and cfg_data. The
// user must write them only while the block is idle; it is not enforced.
// Reset (rst, synchronous) returns the parser to hunting, restores the sync
// values 0xAA and 0xBB, forgets the last accepted serial and empties the
// output register.
// When the receiver stalls, the result register holds its word; bytes are
// still accepted until a further result would need that register, at which
// point in_ready drops until the word has been taken.
// ----------------------------------------------------------------------------
module sync_header_frame_parser_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [shfp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [shfp_pkg::ByteW-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [shfp_pkg::ByteW-1:0]     rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [shfp_pkg::StatusW-1:0]   frame_status,
  output logic [shfp_pkg::ByteW-1:0]     frame_serial,
  output logic [shfp_pkg::ByteW-1:0]     frame_kind,
  output logic [shfp_pkg::ByteW-1:0]     payload_low,
  output logic [shfp_pkg::ByteW-1:0]     payload_high
);
  import shfp_pkg::*;

  logic    accept;
  logic    emit;
  logic    can_take;
  result_t result;
  result_t out_data;

  // Only a check byte produces a result, so only a check byte has to wait
  // for room in the output register. Every other byte is taken at once.
  assign in_ready = !emit || can_take;
  assign accept   = in_valid && in_ready;

  shfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .emit      (emit),
    .result    (result)
  );

  shfp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && emit),
    .load_data (result),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign frame_status = out_data.status;
  assign frame_serial = out_data.serial;
  assign frame_kind   = out_data.kind;
  assign payload_low  = out_data.payload_low;
  assign payload_high = out_data.payload_high;

endmodule

// File: tb/tb_sync_header_frame_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_header_frame_parser_top
// Self-checking bench for the sync header frame parser.
// ----------------------------------------------------------------------------
// Received bytes go in one word at a time through the input handshake. A
// scoreboard tracks the parser from every accepted byte. Each result word
// that should follow is queued, and each result word taken from the block is
// compared field by field with the oldest queued one. The run starts with a
// short hand-built sequence. Randomised frames follow under several sync
// settings, among them all-zero and all-one values and equal sync bytes.
// Both sides insert random idle cycles between words.
// ----------------------------------------------------------------------------
module tb_sync_header_frame_parser_top;
  import shfp_pkg::*;

  typedef logic [ByteW-1:0] byte_t;

  // Parser position within a frame, in stream order.
  typedef enum logic [2:0] {
    PhSync1, PhSync2, PhSerial, PhKind, PhDataLo, PhDataHi, PhCheck
  } frame_phase_t;

  // Ways in which a generated frame is spoiled on purpose.
  localparam int FlawNone      = 0;
  localparam int FlawCheck     = 1;
  localparam int FlawCheckSync = 2;
  localparam int FlawSync2     = 3;

  localparam int FramesPerSetting = 48;
  localparam int MaxPrinted       = 40;

  // --------------------------------------------------------------------------
  // Scoreboard: follows the parser byte by byte and holds the result words
  // still awaited from the block.
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    byte_t        sync_a;
    byte_t        sync_b;
    frame_phase_t phase;
    byte_t        xor_acc;
    byte_t        serial;
    byte_t        kind;
    byte_t        data_lo;
    byte_t        data_hi;
    byte_t        last_serial;
    bit           have_serial;
    result_t      awaited[$];
    int           errors;

    function new();
      sync_a      = SyncFirstRst;
      sync_b      = SyncSecondRst;
      phase       = PhSync1;
      xor_acc     = '0;
      serial      = '0;
      kind        = '0;
      data_lo     = '0;
      data_hi     = '0;
      last_serial = '0;
      have_serial = 1'b0;
      errors      = 0;
    endfunction

    function void set_sync(logic [CfgIdxW-1:0] idx, byte_t value);
      if (idx == CfgSyncFirst) sync_a = value;
      else if (idx == CfgSyncSecond) sync_b = value;
    endfunction

    function void hunt(byte_t b);
      if (b == sync_a) begin
        xor_acc = b;
        phase   = PhSync2;
      end else begin
        phase = PhSync1;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Advances the parser by one accepted byte.
    function void note_byte(byte_t b);
      result_t r;
      case (phase)
        PhSync2: begin
          if (b == sync_b) begin
            xor_acc = xor_acc ^ b;
            phase   = PhSerial;
          end else begin
            hunt(b);
          end
        end
        PhSerial: begin
          xor_acc = xor_acc ^ b;
          serial  = b;
          phase   = PhKind;
        end
        PhKind: begin
          xor_acc = xor_acc ^ b;
          kind    = b;
          phase   = PhDataLo;
        end
        PhDataLo: begin
          xor_acc = xor_acc ^ b;
          data_lo = b;
          phase   = PhDataHi;
        end
        PhDataHi: begin
          xor_acc = xor_acc ^ b;
          data_hi = b;
          phase   = PhCheck;
        end
        PhCheck: begin
          r.serial       = serial;
          r.kind         = kind;
          r.payload_low  = data_lo;
          r.payload_high = data_hi;
          if (xor_acc == b) begin
            phase = PhSync1;
            if (have_serial && serial == last_serial) begin
              r.status = StDup;
            end else begin
              last_serial = serial;
              have_serial = 1'b1;
              r.status    = StNew;
            end
          end else begin
            r.status = StErr;
            hunt(b);
          end
          awaited.push_back(r);
        end
        default: hunt(b);
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxPrinted) $display("%0t ERROR %s", $time, msg);
    endtask

    task check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result word with nothing awaited: status %0d serial %02h",
                         got.status, got.serial));
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status)
        report($sformatf("frame_status %0d, wanted %0d", got.status, want.status));
      if (got.serial !== want.serial)
        report($sformatf("frame_serial %02h, wanted %02h", got.serial, want.serial));
      if (got.kind !== want.kind)
        report($sformatf("frame_kind %02h, wanted %02h", got.kind, want.kind));
      if (got.payload_low !== want.payload_low)
        report($sformatf("payload_low %02h, wanted %02h",
                         got.payload_low, want.payload_low));
      if (got.payload_high !== want.payload_high)
        report($sformatf("payload_high %02h, wanted %02h",
                         got.payload_high, want.payload_high));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Block under test and its connections.
  // --------------------------------------------------------------------------
  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  byte_t               cfg_data;
  logic                in_valid;
  logic                in_ready;
  byte_t               rx_byte;
  logic                out_valid;
  logic                out_ready;
  logic [StatusW-1:0]  frame_status;
  byte_t               frame_serial;
  byte_t               frame_kind;
  byte_t               payload_low;
  byte_t               payload_high;

  frame_scoreboard sb;
  bit              send_calm;
  bit              take_calm;
  byte_t           prev_serial;

  sync_header_frame_parser_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_status (frame_status),
    .frame_serial (frame_serial),
    .frame_kind   (frame_kind),
    .payload_low  (payload_low),
    .payload_high (payload_high)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A generous ceiling: even with every word waiting out the longest idle
  // gap on both sides, the whole run needs well under a tenth of this.
  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driving tasks. Inputs change on the falling edge; handshakes are judged
  // on the rising edge, after every input has settled at the falling edge.
  // --------------------------------------------------------------------------

  // Offers one byte after a random idle spell and waits for it to be taken.
  // When there is no idle spell, valid simply stays high for the new word.
  task automatic send_byte(input byte_t b);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
  endtask

  // Withdraws the sender and holds off until every awaited result is in.
  task automatic hold_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input byte_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_sync(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // New sync values are written only once the block has gone quiet. A byte
  // that yields no result may still be in flight when the last result has
  // left, so a few spare cycles follow the drain.
  task automatic set_sync_pair(input byte_t first_val, input byte_t second_val);
    hold_for_results();
    repeat (4) @(posedge clk);
    write_reg(CfgSyncFirst, first_val);
    write_reg(CfgSyncSecond, second_val);
  endtask

  // Sends a frame built on the current sync values, spoiled as asked.
  task automatic send_frame(input byte_t ser, input byte_t knd, input byte_t lo,
                            input byte_t hi, input int flaw);
    byte_t chk;
    byte_t odd;
    chk = sb.sync_a ^ sb.sync_b ^ ser ^ knd ^ lo ^ hi;
    send_byte(sb.sync_a);
    if (flaw == FlawSync2) begin
      // Anything but the second sync byte; now and then the first sync byte,
      // which has to restart the frame at once.
      odd = ($urandom_range(0, 1) == 0) ? sb.sync_a : byte_t'($urandom);
      if (odd == sb.sync_b) odd = ~odd;
      send_byte(odd);
      return;
    end
    send_byte(sb.sync_b);
    send_byte(ser);
    send_byte(knd);
    send_byte(lo);
    send_byte(hi);
    if (flaw == FlawCheck) begin
      chk = chk ^ byte_t'($urandom_range(1, 255));
    end else if (flaw == FlawCheckSync) begin
      chk = (chk != sb.sync_a) ? sb.sync_a : chk ^ 8'h01;
    end
    send_byte(chk);
  endtask

  // Mostly well-formed frames with random content; the rest are spoiled
  // frames and stray bytes. Serials repeat often enough to give duplicates.
  task automatic random_frames(input int count);
    int    flaw_pick;
    int    flaw;
    int    n;
    byte_t ser;
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) send_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 39) == 0) hold_for_results();
      if ($urandom_range(0, 11) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(($urandom_range(0, 3) == 0) ? sb.sync_a : byte_t'($urandom));
      end
      flaw_pick = $urandom_range(0, 99);
      if (flaw_pick < 70) flaw = FlawNone;
      else if (flaw_pick < 80) flaw = FlawCheck;
      else if (flaw_pick < 88) flaw = FlawCheckSync;
      else flaw = FlawSync2;
      ser = ($urandom_range(0, 3) == 0) ? prev_serial : byte_t'($urandom);
      prev_serial = ser;
      send_frame(ser, byte_t'($urandom), byte_t'($urandom), byte_t'($urandom), flaw);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, with calm stretches, and a check of every
  // word taken.
  // --------------------------------------------------------------------------
  initial begin : result_side
    result_t got;
    int      gap;
    int      taken;
    taken = 0;
    wait (rst == 1'b0);
    forever begin
      if (taken % 8 == 0) take_calm = ($urandom_range(0, 3) == 0);
      gap = take_calm ? 0 : $urandom_range(0, 7);
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.status       = frame_status;
      got.serial       = frame_serial;
      got.kind         = frame_kind;
      got.payload_low  = payload_low;
      got.payload_high = payload_high;
      sb.check_result(got);
      taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    sb          = new();
    send_calm   = 1'b0;
    take_calm   = 1'b0;
    prev_serial = '0;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = CfgSyncFirst;
    cfg_data    = '0;
    in_valid    = 1'b0;
    rx_byte     = '0;
    out_ready   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Hand-built opening under the reset sync values. Serial zero equals the
    // reset value of the last serial, yet must come out as a new frame; the
    // same frame again is then a duplicate.
    send_frame(8'h00, 8'h00, 8'h00, 8'h00, FlawNone);
    send_frame(8'h00, 8'h00, 8'h00, 8'h00, FlawNone);
    // A repeated first sync byte in place of the second one restarts the
    // frame on that byte. The all-ones frame that follows carries a check
    // byte equal to the first sync byte, which restarts the next frame.
    send_byte(8'hAA);
    send_byte(8'hAA);
    send_byte(8'hBB);
    repeat (4) send_byte(8'hFF);
    send_byte(8'hAA);
    send_byte(8'hBB);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h00);
    send_byte(8'hEF);

    random_frames(FramesPerSetting);

    // Extreme sync values both ways round, a random pair, then equal bytes.
    set_sync_pair(8'h00, 8'hFF);
    random_frames(FramesPerSetting);
    set_sync_pair(8'hFF, 8'h00);
    random_frames(FramesPerSetting);
    set_sync_pair(byte_t'($urandom), byte_t'($urandom));
    random_frames(FramesPerSetting);
    set_sync_pair(8'h5A, 8'h5A);
    random_frames(FramesPerSetting);

    // Let the last results drain, then allow a few cycles for anything stray.
    hold_for_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
